### rtl/core/kmeans_1d_clustering_assert.svh
// ----------------------------------------------------------------------------
// kmeans_1d_clustering assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KMEANS_1D_CLUSTERING_ASSERT_SVH
`define KMEANS_1D_CLUSTERING_ASSERT_SVH

// condition must hold at every edge out of reset
`define KMC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define KMC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Types and fixed constants of the one-dimensional k-means block.
// ----------------------------------------------------------------------------
package kmc_pkg;

    localparam int POINT_W  = 16;
    localparam int FRAC_W   = 8;
    localparam int CENT_W   = 24;
    localparam int CIDX_W   = 2;
    localparam int MCNT_W   = 9;
    localparam int SLOTS    = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CENTROID_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CENTROID_3 = 3'd5;

    localparam logic [2:0]        RST_CLUSTER_COUNT   = 3'd2;
    localparam logic [7:0]        RST_ITERATION_COUNT = 8'd10;
    localparam logic [CENT_W-1:0] RST_INIT_CENTROID_0 = 24'd256;
    localparam logic [CENT_W-1:0] RST_INIT_CENTROID_1 = 24'd512;
    localparam logic [CENT_W-1:0] RST_INIT_CENTROID_2 = 24'd0;
    localparam logic [CENT_W-1:0] RST_INIT_CENTROID_3 = 24'd0;

    typedef struct packed {
        logic [POINT_W-1:0] point_value;
        logic               last_point;
    } in_item_t;

    typedef struct packed {
        logic [CIDX_W-1:0] cluster_index;
        logic [CENT_W-1:0] centroid_value;
        logic [MCNT_W-1:0] member_count;
        logic              last_cluster;
    } out_item_t;

endpackage

### rtl/core/kmc_ram.sv
// ----------------------------------------------------------------------------
// kmc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/kmc_div.sv
// ----------------------------------------------------------------------------
// kmc_div
// Restoring divider, one quotient bit per cycle; low CENT_W quotient bits out.
// ----------------------------------------------------------------------------
module kmc_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NUM_W-1:0]          numer,
    input  logic [DEN_W-1:0]          denom,
    output logic                      done,
    output logic [kmc_pkg::CENT_W-1:0] quotient
);

    import kmc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;
    logic [DEN_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg[CENT_W-1:0];

endmodule

### rtl/core/kmeans_1d_clustering.sv
// ----------------------------------------------------------------------------
// kmeans_1d_clustering
// One-dimensional Lloyd k-means over a stored point set, Q16.8 centroids.
// ----------------------------------------------------------------------------
// Points load one per cycle into the point RAM; the transaction that carries
// last_point closes the set and starts a run, during which in_stall is high.
// Each round reads every stored point once from the RAM and passes it through
// the read, distance, select and accumulate stages, then updates each
// non-empty cluster's centroid with a bit-serial divider. After the last
// round one result transaction per cluster leaves through the output
// register, one per cycle when out_stall is low, and loading reopens as the
// last result is queued. No clearing pass follows reset.
module kmeans_1d_clustering #(
    parameter int MAX_POINTS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [kmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  kmc_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output kmc_pkg::out_item_t                 out_data
);

    import kmc_pkg::*;

    `include "kmeans_1d_clustering_assert.svh"

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int SW    = POINT_W + CW;
    localparam int NW    = SW + FRAC_W;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DIVS = 3'd4;
    localparam logic [2:0] ST_DIVW = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    // configuration
    logic [2:0]        cfg_clusters_reg;
    logic [7:0]        cfg_iters_reg;
    logic [CENT_W-1:0] cfg_cent_reg [SLOTS];

    // control
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CW-1:0]     total_reg;
    logic [2:0]        k_reg;
    logic [7:0]        round_reg;
    logic [CW-1:0]     scan_idx_reg;
    logic [CIDX_W-1:0] clus_j_reg;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;
    logic              out_valid_reg;

    // datapath
    logic [CENT_W-1:0]  cent_reg [SLOTS];
    logic [SW-1:0]      sum_reg [SLOTS];
    logic [CW-1:0]      cnt_reg [SLOTS];
    logic [CENT_W-1:0]  s2_dist_reg [SLOTS];
    logic [POINT_W-1:0] s2_point_reg;
    logic [CIDX_W-1:0]  s3_sel_reg;
    logic [POINT_W-1:0] s3_point_reg;
    out_item_t          out_data_reg;

    logic               in_accept;
    logic               store_wr;
    logic               rd_en;
    logic [POINT_W-1:0] rd_data;
    logic [CENT_W-1:0]  scaled;
    logic [CENT_W-1:0]  cent_dist [SLOTS];
    logic [CIDX_W-1:0]  best_sel;
    logic [CENT_W-1:0]  best_dist;
    logic [2:0]         k_calc;
    logic [CIDX_W-1:0]  k_last;
    logic               clus_last;
    logic               round_end;
    logic               div_start;
    logic               div_done;
    logic [NW-1:0]      div_numer;
    logic [CENT_W-1:0]  div_quot;
    logic               out_load;
    logic [CW+MCNT_W-1:0] cnt_ext;

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign store_wr  = in_accept && (total_reg < CW'(MAX_POINTS));
    assign rd_en     = (state_reg == ST_SCAN);

    always_comb
    begin
        k_calc = cfg_clusters_reg;
        if (cfg_clusters_reg == 3'd0)
        begin
            k_calc = 3'd1;
        end
        else if (cfg_clusters_reg > 3'(SLOTS))
        begin
            k_calc = 3'(SLOTS);
        end
    end

    assign k_last    = CIDX_W'(k_reg - 3'd1);
    assign clus_last = (clus_j_reg == k_last);
    assign round_end = clus_last && (round_reg == 8'd0);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_clusters_reg <= RST_CLUSTER_COUNT;
            cfg_iters_reg    <= RST_ITERATION_COUNT;
            cfg_cent_reg[0]  <= RST_INIT_CENTROID_0;
            cfg_cent_reg[1]  <= RST_INIT_CENTROID_1;
            cfg_cent_reg[2]  <= RST_INIT_CENTROID_2;
            cfg_cent_reg[3]  <= RST_INIT_CENTROID_3;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_CLUSTER_COUNT)
            begin
                cfg_clusters_reg <= cfg_data[2:0];
            end
            else if (cfg_index == CFG_ITERATION_COUNT)
            begin
                cfg_iters_reg <= cfg_data[7:0];
            end
            else if (cfg_index >= CFG_INIT_CENTROID_0 && cfg_index <= CFG_INIT_CENTROID_3)
            begin
                cfg_cent_reg[CIDX_W'(cfg_index - CFG_INIT_CENTROID_0)] <= cfg_data[CENT_W-1:0];
            end
        end
    end

    kmc_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (total_reg[AW-1:0]),
        .wr_data (in_data.point_value),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // distance stage
    assign scaled = {rd_data, {FRAC_W{1'b0}}};

    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            cent_dist[j] = (scaled >= cent_reg[j]) ? (scaled - cent_reg[j])
                                                   : (cent_reg[j] - scaled);
        end
    end

    // nearest-centroid select, ties to lower index
    always_comb
    begin
        best_sel  = '0;
        best_dist = s2_dist_reg[0];
        for (int j = 1; j < SLOTS; j++)
        begin
            if ((3'(j) < k_reg) && (s2_dist_reg[j] < best_dist))
            begin
                best_sel  = CIDX_W'(j);
                best_dist = s2_dist_reg[j];
            end
        end
    end

    assign div_numer = {sum_reg[clus_j_reg], {FRAC_W{1'b0}}}
                     + NW'(cnt_reg[clus_j_reg] >> 1);
    assign div_start = (state_reg == ST_DIVS) && (cnt_reg[clus_j_reg] != '0);

    kmc_div #(
        .NUM_W (NW),
        .DEN_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (cnt_reg[clus_j_reg]),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && in_data.last_point)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg + 1'b1 == total_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
                begin
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                if (div_start)
                begin
                    state_next = ST_DIVW;
                end
                else if (round_end)
                begin
                    state_next = ST_EMIT;
                end
                else if (clus_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    if (round_end)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (clus_last)
                    begin
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_load && clus_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            total_reg     <= '0;
            k_reg         <= 3'd1;
            round_reg     <= '0;
            scan_idx_reg  <= '0;
            clus_j_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;

            if (store_wr)
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (in_accept && in_data.last_point)
            begin
                k_reg     <= k_calc;
                round_reg <= (cfg_iters_reg == 8'd0) ? 8'd0 : cfg_iters_reg - 8'd1;
            end

            if (state_reg == ST_INIT)
            begin
                scan_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            if (state_reg == ST_DRAIN)
            begin
                clus_j_reg <= '0;
            end
            else if ((state_reg == ST_DIVS && !div_start) || (state_reg == ST_DIVW && div_done))
            begin
                if (clus_last)
                begin
                    clus_j_reg <= '0;
                    if (round_reg != 8'd0)
                    begin
                        round_reg <= round_reg - 8'd1;
                    end
                end
                else
                begin
                    clus_j_reg <= clus_j_reg + 1'b1;
                end
            end
            else if (out_load)
            begin
                clus_j_reg <= clus_j_reg + 1'b1;
                if (clus_last)
                begin
                    total_reg <= '0;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cnt_ext = {{MCNT_W{1'b0}}, cnt_reg[clus_j_reg]};

    always_ff @(posedge clk)
    begin
        if (in_accept && in_data.last_point)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                cent_reg[j] <= cfg_cent_reg[j];
            end
        end
        else if (state_reg == ST_DIVW && div_done)
        begin
            cent_reg[clus_j_reg] <= div_quot;
        end

        if (s1_valid_reg)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                s2_dist_reg[j] <= cent_dist[j];
            end
            s2_point_reg <= rd_data;
        end
        if (s2_valid_reg)
        begin
            s3_sel_reg   <= best_sel;
            s3_point_reg <= s2_point_reg;
        end

        for (int j = 0; j < SLOTS; j++)
        begin
            if (state_reg == ST_INIT)
            begin
                sum_reg[j] <= '0;
                cnt_reg[j] <= '0;
            end
            else if (s3_valid_reg && (s3_sel_reg == CIDX_W'(j)))
            begin
                sum_reg[j] <= sum_reg[j] + SW'(s3_point_reg);
                cnt_reg[j] <= cnt_reg[j] + 1'b1;
            end
        end

        if (out_load)
        begin
            out_data_reg.cluster_index  <= clus_j_reg;
            out_data_reg.centroid_value <= cent_reg[clus_j_reg];
            out_data_reg.member_count   <= cnt_ext[MCNT_W-1:0];
            out_data_reg.last_cluster   <= clus_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `KMC_ASSERT_ALWAYS(a_total_bound, total_reg <= CW'(MAX_POINTS), "point count overflow")
    `KMC_ASSERT_IMPL(a_scan_nonempty, state_reg == ST_SCAN, total_reg != '0, "scan of empty set")
    `KMC_ASSERT_IMPL(a_acc_in_round, s3_valid_reg,
        state_reg == ST_SCAN || state_reg == ST_DRAIN, "accumulate outside scan")
    `KMC_ASSERT_IMPL(a_div_done_wait, div_done, state_reg == ST_DIVW, "unexpected divide done")
    `KMC_ASSERT_IMPL(a_clus_in_range, state_reg == ST_EMIT || state_reg == ST_DIVS,
        3'(clus_j_reg) < k_reg, "cluster index beyond count")

endmodule
